// ----- src/tia_pkg.sv -----
package tia_pkg;

  localparam int unsigned W   = 32;
  localparam int unsigned SHW = $clog2(W);

  typedef enum logic [4:0] {
    CMD_ADD  = 5'd0,
    CMD_SUB  = 5'd1,
    CMD_MUL  = 5'd2,
    CMD_DIV  = 5'd3,
    CMD_MOD  = 5'd4,
    CMD_OR   = 5'd5,
    CMD_XOR  = 5'd6,
    CMD_AND  = 5'd7,
    CMD_SHL  = 5'd8,
    CMD_LT   = 5'd9,
    CMD_GT   = 5'd10,
    CMD_EQ   = 5'd11,
    CMD_NE   = 5'd12,
    CMD_LE   = 5'd13,
    CMD_GE   = 5'd14,
    CMD_LAND = 5'd15,
    CMD_LOR  = 5'd16,
    CMD_LXOR = 5'd17,
    CMD_NOT  = 5'd18,
    CMD_ABS  = 5'd19,
    CMD_SIGN = 5'd20,
    CMD_INC  = 5'd21,
    CMD_DEC  = 5'd22
  } cmd_e;

  typedef enum logic [1:0] {
    TAG_INT  = 2'd0,
    TAG_OBJ  = 2'd1,
    TAG_GVAR = 2'd2,
    TAG_LVAR = 2'd3
  } tag_e;

  typedef struct packed {
    logic [W-1:0] res;
    logic [1:0]   rtag;
    logic         ovf;
    logic         dz;
    logic         terr;
    logic         is_mul;
    logic         is_div;
    logic         is_mod;
    logic         q_neg;
    logic         r_neg;
  } meta_t;

  typedef struct packed {
    meta_t        meta;
    logic [W-1:0] a;
    logic [W-1:0] b;
  } dec_t;

  typedef struct packed {
    meta_t        meta;
    logic [W-1:0] dvd;
    logic [W-1:0] dvs;
    logic [W:0]   rem;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t       r;
    logic [W:0] sh;
    r  = s;
    sh = {s.rem[W-1:0], s.dvd[W-1]};
    r.dvd = {s.dvd[W-2:0], 1'b0};
    if (sh >= {1'b0, s.dvs}) begin
      r.rem    = sh - {1'b0, s.dvs};
      r.dvd[0] = 1'b1;
    end else begin
      r.rem = sh;
    end
    return r;
  endfunction

endpackage

// ----- src/tia_if.sv -----
interface tia_in_if;
  import tia_pkg::*;
  logic                valid;
  logic                ready;
  logic [4:0]          command;
  logic signed [W-1:0] a_value;
  logic [1:0]          a_tag;
  logic signed [W-1:0] b_value;
  logic [1:0]          b_tag;
  modport source (output valid, command, a_value, a_tag, b_value, b_tag, input ready);
  modport sink (input valid, command, a_value, a_tag, b_value, b_tag, output ready);
endinterface

interface tia_out_if;
  import tia_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [W-1:0] result_value;
  logic [1:0]          result_tag;
  logic                overflow;
  logic                div_by_zero;
  logic                type_error;
  modport source (output valid, result_value, result_tag, overflow, div_by_zero, type_error,
                  input ready);
  modport sink (input valid, result_value, result_tag, overflow, div_by_zero, type_error,
                output ready);
endinterface

// ----- src/tia_decode.sv -----
module tia_decode (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     en_i,
  input  logic                     vld_i,
  input  logic [4:0]               cmd_i,
  input  logic [tia_pkg::W-1:0]    a_i,
  input  logic [1:0]               at_i,
  input  logic [tia_pkg::W-1:0]    b_i,
  input  logic [1:0]               bt_i,
  output logic                     vld_o,
  output tia_pkg::dec_t            dec_o
);
  import tia_pkg::*;

  localparam logic [W-1:0] WLIM = W[W-1:0];
  localparam logic [W-1:0] SMAX = W[W-1:0] - 1'b1;

  cmd_e         cmd;
  dec_t         dec_d, dec_q;
  logic         vld_q;
  logic         terr, fa, fb, slt_ab, slt_ba;
  logic [W-1:0] sum, dif, magb, shv;
  logic [SHW-1:0] n;

  always_comb begin
    cmd    = cmd_e'(cmd_i);
    sum    = a_i + b_i;
    dif    = a_i - b_i;
    slt_ab = $signed(a_i) < $signed(b_i);
    slt_ba = $signed(b_i) < $signed(a_i);
    fa     = (at_i == TAG_INT) ? (a_i == '0) : ((at_i == TAG_OBJ) ? (a_i == '1) : 1'b0);
    fb     = (bt_i == TAG_INT) ? (b_i == '0) : ((bt_i == TAG_OBJ) ? (b_i == '1) : 1'b0);
    magb   = '0 - b_i;
    n      = (magb > SMAX) ? SMAX[SHW-1:0] : magb[SHW-1:0];
    if (b_i == '0) begin
      shv = a_i;
    end else if (!b_i[W-1]) begin
      shv = (b_i >= WLIM) ? '0 : (a_i << b_i[SHW-1:0]);
    end else begin
      shv = $unsigned($signed(a_i) >>> n);
    end

    dec_d      = '0;
    dec_d.a    = a_i;
    dec_d.b    = b_i;
    terr       = 1'b0;
    case (cmd)
      CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV, CMD_MOD, CMD_OR, CMD_XOR, CMD_AND, CMD_SHL: begin
        terr            = (bt_i != TAG_INT);
        dec_d.meta.rtag = at_i;
      end
      CMD_LT, CMD_GT, CMD_EQ, CMD_NE, CMD_LE, CMD_GE: terr = at_i[1] | bt_i[1];
      CMD_LAND, CMD_LOR, CMD_LXOR, CMD_NOT: terr = 1'b0;
      CMD_ABS, CMD_SIGN: terr = (bt_i != TAG_INT);
      CMD_INC, CMD_DEC: begin
        terr            = bt_i[1];
        dec_d.meta.rtag = bt_i;
      end
      default: terr = 1'b1;
    endcase

    case (cmd)
      CMD_ADD: begin
        dec_d.meta.res = sum;
        dec_d.meta.ovf = (a_i[W-1] == b_i[W-1]) && (sum[W-1] != a_i[W-1]);
      end
      CMD_SUB: begin
        dec_d.meta.res = dif;
        dec_d.meta.ovf = (a_i[W-1] != b_i[W-1]) && (dif[W-1] != a_i[W-1]);
      end
      CMD_MUL: dec_d.meta.is_mul = 1'b1;
      CMD_DIV: begin
        if (b_i == '0) begin
          dec_d.meta.dz = 1'b1;
        end else begin
          dec_d.meta.is_div = 1'b1;
          dec_d.meta.q_neg  = a_i[W-1] ^ b_i[W-1];
          dec_d.meta.ovf    = (a_i == {1'b1, {(W-1){1'b0}}}) && (b_i == '1);
        end
      end
      CMD_MOD: begin
        dec_d.meta.is_mod = (b_i != '0);
        dec_d.meta.r_neg  = a_i[W-1];
      end
      CMD_OR:   dec_d.meta.res = a_i | b_i;
      CMD_XOR:  dec_d.meta.res = a_i ^ b_i;
      CMD_AND:  dec_d.meta.res = a_i & b_i;
      CMD_SHL:  dec_d.meta.res = shv;
      CMD_LT:   dec_d.meta.res = W'(slt_ab);
      CMD_GT:   dec_d.meta.res = W'(slt_ba);
      CMD_EQ:   dec_d.meta.res = W'(a_i == b_i);
      CMD_NE:   dec_d.meta.res = W'(a_i != b_i);
      CMD_LE:   dec_d.meta.res = W'(!slt_ba);
      CMD_GE:   dec_d.meta.res = W'(!slt_ab);
      CMD_LAND: dec_d.meta.res = W'(!fa && !fb);
      CMD_LOR:  dec_d.meta.res = W'(!fa || !fb);
      CMD_LXOR: dec_d.meta.res = W'(fa != fb);
      CMD_NOT:  dec_d.meta.res = W'(fb);
      CMD_ABS:  dec_d.meta.res = b_i[W-1] ? magb : b_i;
      CMD_SIGN: dec_d.meta.res = (b_i == '0) ? '0 : (b_i[W-1] ? '1 : W'(1));
      CMD_INC:  dec_d.meta.res = b_i + W'(1);
      CMD_DEC:  dec_d.meta.res = b_i - W'(1);
      default:  dec_d.meta.res = '0;
    endcase

    if (terr) begin
      dec_d.meta      = '0;
      dec_d.meta.terr = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dec_q <= dec_d;
    end
  end

  assign vld_o = vld_q;
  assign dec_o = dec_q;
endmodule

// ----- src/tia_mul.sv -----
module tia_mul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  tia_pkg::dec_t dec_i,
  output logic          vld_o,
  output tia_pkg::div_t div_o
);
  import tia_pkg::*;

  div_t           div_d, div_q;
  logic           vld_q;
  logic [2*W-1:0] prod;

  always_comb begin
    prod       = $signed(dec_i.a) * $signed(dec_i.b);
    div_d      = '0;
    div_d.meta = dec_i.meta;
    div_d.dvd  = dec_i.a[W-1] ? ('0 - dec_i.a) : dec_i.a;
    div_d.dvs  = dec_i.b[W-1] ? ('0 - dec_i.b) : dec_i.b;
    if (dec_i.meta.is_mul) begin
      div_d.meta.res = prod[W-1:0];
      div_d.meta.ovf = (prod[2*W-1:W-1] != '0) && (prod[2*W-1:W-1] != '1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q <= div_d;
    end
  end

  assign vld_o = vld_q;
  assign div_o = div_q;
endmodule

// ----- src/tia_divider.sv -----
module tia_divider (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          vld_i,
  input  tia_pkg::div_t div_i,
  output logic          vld_o,
  output tia_pkg::div_t div_o
);
  import tia_pkg::*;

  // one quotient bit per stage, MSB first
  div_t stg_q [W];
  logic [W-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[W-2:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0] <= div_step(div_i);
      for (int k = 1; k < W; k++) begin
        stg_q[k] <= div_step(stg_q[k-1]);
      end
    end
  end

  assign vld_o = vld_q[W-1];
  assign div_o = stg_q[W-1];
endmodule

// ----- src/tagged_integer_alu.sv -----
// Stages from input transfer to result transfer, in order: decode, multiply,
// 32 divider stages, output register.
// Throughput: one item per cycle unless stalled; one quotient bit per divider stage.
// A stalled output holds the whole pipeline in place.
// Reset (rst_ni low, asynchronous) clears all valid bits; no item is in flight.
module tagged_integer_alu (
  input  logic clk_i,
  input  logic rst_ni,
  tia_in_if.sink    in_i,
  tia_out_if.source out_o
);
  import tia_pkg::*;

  logic         en, dec_vld, mul_vld, div_vld, out_vld_q;
  dec_t         dec;
  div_t         mdv, dvo;
  logic [W-1:0] res_d, res_q;
  logic [1:0]   rtag_q;
  logic         ovf_q, dz_q, terr_q;

  assign en         = !out_vld_q || out_o.ready;
  assign in_i.ready = en;

  tia_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (in_i.valid),
    .cmd_i  (in_i.command),
    .a_i    ($unsigned(in_i.a_value)),
    .at_i   (in_i.a_tag),
    .b_i    ($unsigned(in_i.b_value)),
    .bt_i   (in_i.b_tag),
    .vld_o  (dec_vld),
    .dec_o  (dec)
  );

  tia_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (dec_vld),
    .dec_i  (dec),
    .vld_o  (mul_vld),
    .div_o  (mdv)
  );

  tia_divider u_divider (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (mul_vld),
    .div_i  (mdv),
    .vld_o  (div_vld),
    .div_o  (dvo)
  );

  always_comb begin
    if (dvo.meta.is_div) begin
      res_d = dvo.meta.q_neg ? ('0 - dvo.dvd) : dvo.dvd;
    end else if (dvo.meta.is_mod) begin
      res_d = dvo.meta.r_neg ? ('0 - dvo.rem[W-1:0]) : dvo.rem[W-1:0];
    end else begin
      res_d = dvo.meta.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= div_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q  <= res_d;
      rtag_q <= dvo.meta.rtag;
      ovf_q  <= dvo.meta.ovf;
      dz_q   <= dvo.meta.dz;
      terr_q <= dvo.meta.terr;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.result_value = $signed(res_q);
  assign out_o.result_tag   = rtag_q;
  assign out_o.overflow     = ovf_q;
  assign out_o.div_by_zero  = dz_q;
  assign out_o.type_error   = terr_q;
endmodule
